FILE: src/dft16sl_pkg.sv
// Package: shared types, constants and twiddle functions for the DFT16 level unit.
`timescale 1ns / 1ps

package dft16sl_pkg;

  localparam int FRAME_LEN = 16;
  localparam int NUM_BINS  = 8;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int SAMPLE_W  = 8;
  localparam int ACC_W     = 16;
  localparam int SQ_W      = 27;
  localparam int LEVEL_W   = 4;
  localparam int PWR_SHIFT = 12;
  localparam int PWR_MAX   = 255;

  // round(127*cos(2*pi*m/16))
  localparam logic signed [7:0] COS_Q7 [FRAME_LEN] = '{
    8'sd127, 8'sd117, 8'sd90, 8'sd49, 8'sd0, -8'sd49, -8'sd90, -8'sd117,
    -8'sd127, -8'sd117, -8'sd90, -8'sd49, 8'sd0, 8'sd49, 8'sd90, 8'sd117
  };

  // Control that travels with one term through the MAC pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastj;
    logic [BIN_W-1:0] bin;
  } mac_ctl_t;

  // Finished bin sums are ready.
  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] bin;
  } bin_done_t;

  function automatic logic signed [7:0] twiddle_re(logic [IDX_W-1:0] m);
    return COS_Q7[m];
  endfunction

  // -sin(a) == -cos(a + 3*pi/2), i.e. index offset of 12
  function automatic logic signed [7:0] twiddle_im(logic [IDX_W-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = m + IDX_W'(12);
    return -COS_Q7[idx];
  endfunction

  // Count of k in 1..8 with (2k-1)^2 <= v.
  function automatic logic [LEVEL_W-1:0] level_of(logic [7:0] v);
    logic [LEVEL_W-1:0] n;
    logic [7:0]         odd;
    n = '0;
    for (int k = 1; k <= 8; k++) begin
      odd = 8'(2 * k - 1);
      if (16'(odd) * 16'(odd) <= 16'(v)) n = n + LEVEL_W'(1);
    end
    return n;
  endfunction

endpackage

FILE: src/dft16_spectrum_levels_unit.sv
// Top level: 16-point DFT level unit with frame memory, sequencer and level stage.
`timescale 1ns / 1ps

// Channel | Ports                 | Beat taken when
// --------+-----------------------+---------------------------
// in      | start, busy, sample   | start high and busy low
// out     | strobe, level,bin,last| strobe high (one cycle)
//
// A sample that is not the 16th of its frame is written to the frame memory
// and busy stays low. The 16th sample raises busy while the sequencer issues
// 128 terms (one memory read and one re/im multiply pair per cycle, bins 0..7 by
// samples 0..15) and while the pipeline then drains.
// Eight result beats come out in bin order during that window; the last one
// carries last=1 and busy drops on the following cycle.
// Synchronous reset clears the fill count, sequencer and valid flags; the frame
// memory is not cleared, every entry is written before a frame is read.
// The receiver cannot stall: each result is shown for exactly one cycle.

module dft16_spectrum_levels_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [dft16sl_pkg::SAMPLE_W-1:0]      sample,
  output logic                                  busy,
  output logic                                  strobe,
  output logic [dft16sl_pkg::LEVEL_W-1:0]       level,
  output logic [dft16sl_pkg::BIN_W-1:0]         bin,
  output logic                                  last
);

  localparam int CNT_W = dft16sl_pkg::IDX_W + dft16sl_pkg::BIN_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [dft16sl_pkg::IDX_W-1:0]    fill;
  logic [CNT_W-1:0]                 cnt;
  logic                             accept;
  logic [dft16sl_pkg::IDX_W-1:0]    rd_idx;
  logic [dft16sl_pkg::BIN_W-1:0]    rd_bin;

  // Frame memory: one write port (input beats), one read port (sequencer)
  logic [dft16sl_pkg::SAMPLE_W-1:0] mem [dft16sl_pkg::FRAME_LEN];
  logic [dft16sl_pkg::SAMPLE_W-1:0] rd_data;

  dft16sl_pkg::mac_ctl_t            s1;
  logic [dft16sl_pkg::IDX_W-1:0]    s1_m;

  logic signed [dft16sl_pkg::ACC_W-1:0] acc_re;
  logic signed [dft16sl_pkg::ACC_W-1:0] acc_im;
  dft16sl_pkg::bin_done_t           done;

  logic [dft16sl_pkg::SQ_W-1:0]     sq_re;
  logic [dft16sl_pkg::SQ_W-1:0]     sq_im;
  logic                             s4_valid;
  logic [dft16sl_pkg::BIN_W-1:0]    s4_bin;
  logic [dft16sl_pkg::SQ_W:0]       pwr_sum;
  logic [dft16sl_pkg::SQ_W-dft16sl_pkg::PWR_SHIFT:0] pwr_shift;
  logic [7:0]                       pwr;

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;
  assign rd_idx = cnt[dft16sl_pkg::IDX_W-1:0];
  assign rd_bin = cnt[CNT_W-1:dft16sl_pkg::IDX_W];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (fill == dft16sl_pkg::IDX_W'(dft16sl_pkg::FRAME_LEN - 1)))
          state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cnt == {CNT_W{1'b1}}) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (strobe && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) fill <= fill + dft16sl_pkg::IDX_W'(1);
      if (state == ST_ISSUE) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Frame memory: writes only while idle, reads only while issuing, so the
  // two ports never touch the same entry in one cycle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) mem[fill] <= sample;
    if (state == ST_ISSUE) rd_data <= mem[rd_idx];
  end

  // Control aligned with the read data; twiddle index is bin*j mod 16
  always_ff @(posedge clk) begin
    s1_m <= dft16sl_pkg::IDX_W'(rd_bin * rd_idx);
    if (rst) begin
      s1 <= '0;
    end else begin
      s1.valid <= (state == ST_ISSUE);
      s1.first <= (rd_idx == '0);
      s1.lastj <= (rd_idx == {dft16sl_pkg::IDX_W{1'b1}});
      s1.bin   <= rd_bin;
    end
  end

  dft16sl_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (s1),
    .m      (s1_m),
    .data   (rd_data),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .done   (done)
  );

  // ---------------------------------------------------------------------
  // Power and level. Squares are registered, then summed, scaled, clamped.
  // |sum| <= 10160, so each square fits in 27 bits.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (done.valid) begin
      sq_re <= dft16sl_pkg::SQ_W'(acc_re) * dft16sl_pkg::SQ_W'(acc_re);
      sq_im <= dft16sl_pkg::SQ_W'(acc_im) * dft16sl_pkg::SQ_W'(acc_im);
    end
    s4_bin <= done.bin;
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= done.valid;
  end

  assign pwr_sum   = {1'b0, sq_re} + {1'b0, sq_im};
  assign pwr_shift = pwr_sum[dft16sl_pkg::SQ_W:dft16sl_pkg::PWR_SHIFT];
  assign pwr       = (pwr_shift > 16'(dft16sl_pkg::PWR_MAX)) ? 8'(dft16sl_pkg::PWR_MAX)
                                                             : pwr_shift[7:0];

  always_ff @(posedge clk) begin
    level <= dft16sl_pkg::level_of(pwr);
    bin   <= s4_bin;
    last  <= (s4_bin == dft16sl_pkg::BIN_W'(dft16sl_pkg::NUM_BINS - 1));
    if (rst) strobe <= 1'b0;
    else     strobe <= s4_valid;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_strobe_in_frame: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat outside a frame evaluation");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy && !strobe)
    else $error("frame did not end after the last bin");

  a_last_is_top_bin: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> bin == dft16sl_pkg::BIN_W'(dft16sl_pkg::NUM_BINS - 1))
    else $error("last flag on a bin other than the top one");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    accept && (fill == dft16sl_pkg::IDX_W'(dft16sl_pkg::FRAME_LEN - 1)) |=>
      busy && (fill == '0))
    else $error("sixteenth sample did not start evaluation");

endmodule

FILE: src/dft16sl_mac.sv
// Twiddle multiply, scale and accumulate pipeline for the real and imaginary sums.
`timescale 1ns / 1ps

module dft16sl_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dft16sl_pkg::mac_ctl_t                    ctl,
  input  logic [dft16sl_pkg::IDX_W-1:0]            m,
  input  logic [dft16sl_pkg::SAMPLE_W-1:0]         data,
  output logic signed [dft16sl_pkg::ACC_W-1:0]     acc_re,
  output logic signed [dft16sl_pkg::ACC_W-1:0]     acc_im,
  output dft16sl_pkg::bin_done_t                   done
);

  logic signed [7:0]      centred;
  logic signed [15:0]     p_re;
  logic signed [15:0]     p_im;
  dft16sl_pkg::mac_ctl_t  s2;
  logic signed [10:0]     term_re;
  logic signed [10:0]     term_im;

  // sample - 128 is the sample with its top bit flipped, read as signed
  assign centred = $signed(data ^ 8'h80);

  always_ff @(posedge clk) begin
    p_re <= 16'(centred) * 16'(dft16sl_pkg::twiddle_re(m));
    p_im <= 16'(centred) * 16'(dft16sl_pkg::twiddle_im(m));
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= ctl;
    end
  end

  // p/128 toward zero, then *5
  function automatic logic signed [10:0] scale(logic signed [15:0] p);
    logic signed [8:0]  q;
    logic signed [10:0] q11;
    q = 9'(p >>> 7);
    if (p[15] && (p[6:0] != 7'd0)) q = q + 9'sd1;
    q11 = {{2{q[8]}}, q};
    return (q11 <<< 2) + q11;
  endfunction

  assign term_re = scale(p_re);
  assign term_im = scale(p_im);

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc_re <= (s2.first ? '0 : acc_re) + {{5{term_re[10]}}, term_re};
      acc_im <= (s2.first ? '0 : acc_im) + {{5{term_im[10]}}, term_im};
    end
    if (rst) begin
      done <= '0;
    end else begin
      done.valid <= s2.valid & s2.lastj;
      done.bin   <= s2.bin;
    end
  end

endmodule

FILE: dv/dft16sl_level_checker.sv
// Checker: predicts bin levels for each finished frame and compares result beats.
`timescale 1ns / 1ps

module dft16sl_level_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [dft16sl_pkg::SAMPLE_W-1:0] sample,
  input  logic                             strobe,
  input  logic [dft16sl_pkg::LEVEL_W-1:0]  level,
  input  logic [dft16sl_pkg::BIN_W-1:0]    bin,
  input  logic                             last,
  output int                               errors,
  output int                               outstanding
);

  typedef struct {
    logic [dft16sl_pkg::LEVEL_W-1:0] level;
    logic [dft16sl_pkg::BIN_W-1:0]   bin;
    logic                            last;
  } bin_level_t;

  logic [dft16sl_pkg::SAMPLE_W-1:0] frame_mem [dft16sl_pkg::FRAME_LEN];
  logic [dft16sl_pkg::IDX_W-1:0]    fill_pos;
  bin_level_t                       levels_due [$];

  // Quarter-wave table, mirrored out to a full period.
  function automatic int cos_q7(input int m);
    int q;
    int mag;
    q = m & 15;
    if (q > 8) q = 16 - q;
    case ((q > 4) ? 8 - q : q)
      0:       mag = 127;
      1:       mag = 117;
      2:       mag = 90;
      3:       mag = 49;
      default: mag = 0;
    endcase
    return (q > 4) ? -mag : mag;
  endfunction

  function automatic logic [dft16sl_pkg::LEVEL_W-1:0] bin_level(input int b);
    int re;
    int im;
    int centred;
    int m;
    int power;
    logic [dft16sl_pkg::LEVEL_W-1:0] n;
    re = 0;
    im = 0;
    for (int j = 0; j < dft16sl_pkg::FRAME_LEN; j++) begin
      m = (b * j) & 15;
      centred = int'(frame_mem[j]) - 128;
      re += ((centred * cos_q7(m)) / 128) * 5;
      im += ((centred * -cos_q7(m + 12)) / 128) * 5;
    end
    power = (re * re + im * im) >> 12;
    if (power > 255) power = 255;
    n = '0;
    for (int k = 1; k <= 8; k++)
      if ((2 * k - 1) * (2 * k - 1) <= power) n = n + dft16sl_pkg::LEVEL_W'(1);
    return n;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
    fill_pos = '0;
  end

  always @(posedge clk) begin
    bin_level_t want;
    if (rst) begin
      fill_pos = '0;
      levels_due.delete();
    end else begin
      if (strobe) begin
        if (levels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat bin %0d level %0d last %0d",
                   $time, bin, level, last);
        end else begin
          want = levels_due.pop_front();
          if (level !== want.level) begin
            errors++;
            $display("%0t: bin %0d level expected %0d, got %0d",
                     $time, want.bin, want.level, level);
          end
          if (bin !== want.bin) begin
            errors++;
            $display("%0t: bin expected %0d, got %0d", $time, want.bin, bin);
          end
          if (last !== want.last) begin
            errors++;
            $display("%0t: bin %0d last expected %0d, got %0d",
                     $time, want.bin, want.last, last);
          end
        end
      end
      if (start && !busy) begin
        frame_mem[fill_pos] = sample;
        // 16th sample closes the frame: eight bins, bin 7 flagged last
        if (fill_pos == dft16sl_pkg::IDX_W'(dft16sl_pkg::FRAME_LEN - 1)) begin
          for (int b = 0; b < dft16sl_pkg::NUM_BINS; b++) begin
            want.level = bin_level(b);
            want.bin   = dft16sl_pkg::BIN_W'(b);
            want.last  = (b == dft16sl_pkg::NUM_BINS - 1);
            levels_due.push_back(want);
          end
        end
        fill_pos = fill_pos + dft16sl_pkg::IDX_W'(1);
      end
    end
    outstanding = levels_due.size();
  end

endmodule

FILE: dv/tb.sv
// Testbench top: sample stimulus, watchdog and verdict for the DFT16 level unit.
`timescale 1ns / 1ps

// Stimulus plan
//   - One directed frame: eight samples at full scale (255) then eight at
//     zero, a hard square wave that lights the odd bins and checks both
//     rails of the sample range. The first fifteen beats of every frame
//     exercise the partial-frame path (no result), the sixteenth the
//     frame-end path (eight beats, fill count wraps).
//   - Random frames: white noise, square-wave tones at a random bin with
//     random amplitude and phase (reaches the high levels), DC frames and
//     rail-only frames.
//   - A few stray samples at the end leave a partial frame behind; they
//     must cause nothing.
// Beats go out in bursts of random length separated by random gaps, so the
// gaps land both on idle cycles and inside the busy window of a frame.
// Inputs change on the falling edge; everything is sampled on the rising edge.

module tb;

  localparam int QUIET_LIMIT  = 2000; // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 140;  // frame busy window plus margin
  localparam int RANDOM_FRAMES = 17;  // about 300 samples

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic [dft16sl_pkg::SAMPLE_W-1:0] sample;
  logic                             busy;
  logic                             strobe;
  logic [dft16sl_pkg::LEVEL_W-1:0]  level;
  logic [dft16sl_pkg::BIN_W-1:0]    bin;
  logic                             last;

  int errors;
  int outstanding;
  int quiet_cycles;
  int burst_left;

  dft16_spectrum_levels_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .busy   (busy),
    .strobe (strobe),
    .level  (level),
    .bin    (bin),
    .last   (last)
  );

  dft16sl_level_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .strobe      (strobe),
    .level       (level),
    .bin         (bin),
    .last        (last),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a hang shows up as a long run with no beat on either channel.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One input beat. Opens a new burst (after a random gap) when the last one
  // ran out; start stays high across beats of the same burst.
  task automatic send_sample(input logic [dft16sl_pkg::SAMPLE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        start  = 1'b0;
        sample = dft16sl_pkg::SAMPLE_W'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    start  = 1'b1;
    sample = v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random frame of one of several shapes.
  task automatic send_frame();
    int shape;
    int tone_bin;
    int amp;
    int phase;
    int dc;
    int noise;
    int v;
    shape    = $urandom_range(0, 5);
    tone_bin = $urandom_range(0, 8);
    amp      = $urandom_range(0, 127);
    phase    = $urandom_range(0, 15);
    dc       = $urandom_range(0, 255);
    noise    = (shape == 2) ? 40 : 4;
    for (int j = 0; j < dft16sl_pkg::FRAME_LEN; j++) begin
      case (shape)
        0: v = $urandom_range(0, 255);
        1, 2: begin
          // square wave at tone_bin: half the period high, half low
          v = ((((tone_bin * j) + phase) & 15) < 8) ? 128 + amp : 128 - amp;
          v += $urandom_range(0, 2 * noise) - noise;
        end
        3: v = dc;
        default: v = $urandom_range(0, 1) ? 255 : 0;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      send_sample(dft16sl_pkg::SAMPLE_W'(v));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    sample     = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: rails, half-frame square wave
    for (int j = 0; j < dft16sl_pkg::FRAME_LEN; j++)
      send_sample((j < dft16sl_pkg::FRAME_LEN / 2) ? 8'd255 : 8'd0);

    for (int f = 0; f < RANDOM_FRAMES; f++)
      send_frame();

    // trailing partial frame: stored, no result
    repeat ($urandom_range(1, 15)) send_sample(dft16sl_pkg::SAMPLE_W'($urandom));

    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
